// File: sv/rcfp_pkg.sv
// Package for the read command frame parser.
// Holds payload structs, the queue entry type, kind and status codes.
// No dependencies.
`default_nettype none

package rcfp_pkg;

    // Defaults handed to the top level parameters
    localparam int MAX_SERVICES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Frame layout
    localparam logic [3:0] MIN_FRAME = 4'd12;

    // Result kinds
    localparam logic [1:0] KIND_ID    = 2'd0;
    localparam logic [1:0] KIND_SVC   = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // End status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_BAD_SVC   = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  item_index;
        logic [15:0] item_value;
        logic [3:0]  service_order;
        logic [2:0]  acc_mode;
        logic        short_form;
        logic [1:0]  status;
        logic [4:0]  service_total;
        logic [7:0]  block_total;
        logic        frame_done;
    } t_out_item;

    // One queue entry: an optional data result and an optional end result
    typedef struct packed {
        logic        has_data;
        logic        has_end;
        logic [1:0]  kind;
        logic [7:0]  index;
        logic [15:0] value;
        logic [7:0]  header;
        logic [1:0]  status;
        logic [4:0]  svc_total;
        logic [7:0]  blk_total;
    } t_entry;

endpackage

`default_nettype wire

// File: sv/rcfp_front.sv
// Front end of the read command frame parser: per-byte phase tracking.
// Classifies each accepted byte and builds a queue entry. Uses rcfp_pkg.
`default_nettype none

module rcfp_front #(
    parameter int MAX_SERVICES = rcfp_pkg::MAX_SERVICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rcfp_pkg::t_in_item i_item,
    output logic              o_push,
    output rcfp_pkg::t_entry  o_entry
);
    import rcfp_pkg::*;

    localparam int SvcW = $clog2(MAX_SERVICES + 1);

    // Phase codes
    localparam logic [2:0] PH_ID        = 3'd0;
    localparam logic [2:0] PH_SVC_COUNT = 3'd1;
    localparam logic [2:0] PH_SVC       = 3'd2;
    localparam logic [2:0] PH_BLK_COUNT = 3'd3;
    localparam logic [2:0] PH_BLK_HDR   = 3'd4;
    localparam logic [2:0] PH_BLK_DATA  = 3'd5;
    localparam logic [2:0] PH_DONE      = 3'd6;
    localparam logic [2:0] PH_ERR       = 3'd7;

    localparam logic [2:0] ID_LAST = 3'd7;

    logic [2:0]      r_phase,     n_phase;
    logic [3:0]      r_byte_count, n_byte_count;
    logic [2:0]      r_pos,       n_pos;
    logic [SvcW-1:0] r_svc_decl,  n_svc_decl;
    logic [SvcW-1:0] r_svc_pos,   n_svc_pos;
    logic [7:0]      r_blk_decl,  n_blk_decl;
    logic [7:0]      r_blk_pos,   n_blk_pos;
    logic [7:0]      r_hdr,       n_hdr;
    logic [7:0]      r_low,       n_low;

    logic [7:0]      b;
    logic [SvcW-1:0] svc_inc;
    logic [7:0]      blk_inc;
    t_entry          entry;

    assign b       = i_item.in_byte;
    assign svc_inc = r_svc_pos + SvcW'(1);
    assign blk_inc = r_blk_pos + 8'd1;

    // Next state and entry build
    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_svc_decl   = r_svc_decl;
        n_svc_pos    = r_svc_pos;
        n_blk_decl   = r_blk_decl;
        n_blk_pos    = r_blk_pos;
        n_hdr        = r_hdr;
        n_low        = r_low;
        n_byte_count = (r_byte_count < MIN_FRAME) ? r_byte_count + 4'd1 : r_byte_count;

        entry        = '0;

        unique case (r_phase)
            PH_ID: begin
                entry.has_data = 1'b1;
                entry.kind     = KIND_ID;
                entry.index    = {5'd0, r_pos};
                entry.value    = {8'd0, b};
                if (r_pos == ID_LAST) begin
                    n_pos   = 3'd0;
                    n_phase = PH_SVC_COUNT;
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
            PH_SVC_COUNT: begin
                if (b == 8'd0 || b > 8'(MAX_SERVICES)) begin
                    n_phase = PH_ERR;
                end else begin
                    n_svc_decl = b[SvcW-1:0];
                    n_svc_pos  = '0;
                    n_pos      = 3'd0;
                    n_phase    = PH_SVC;
                end
            end
            PH_SVC: begin
                if (r_pos == 3'd0) begin
                    n_low = b;
                    n_pos = 3'd1;
                end else begin
                    entry.has_data = 1'b1;
                    entry.kind     = KIND_SVC;
                    entry.index    = 8'(r_svc_pos);
                    entry.value    = {r_low, b};
                    n_svc_pos      = svc_inc;
                    n_pos          = 3'd0;
                    if (svc_inc >= r_svc_decl) begin
                        n_phase = PH_BLK_COUNT;
                    end
                end
            end
            PH_BLK_COUNT: begin
                n_blk_decl = b;
                n_blk_pos  = 8'd0;
                n_phase    = (b == 8'd0) ? PH_DONE : PH_BLK_HDR;
            end
            PH_BLK_HDR: begin
                n_hdr   = b;
                n_pos   = 3'd0;
                n_phase = PH_BLK_DATA;
            end
            PH_BLK_DATA: begin
                if (r_hdr[7] || r_pos != 3'd0) begin
                    entry.has_data = 1'b1;
                    entry.kind     = KIND_BLOCK;
                    entry.index    = r_blk_pos;
                    entry.value    = r_hdr[7] ? {8'd0, b} : {b, r_low};
                    entry.header   = r_hdr;
                    n_blk_pos      = blk_inc;
                    n_pos          = 3'd0;
                    n_phase        = (blk_inc == r_blk_decl) ? PH_DONE : PH_BLK_HDR;
                end else begin
                    n_low = b;
                    n_pos = 3'd1;
                end
            end
            default: begin
                // done or error: bytes ignored
            end
        endcase

        // End of frame: status, totals, then back to reset values
        if (i_item.in_last) begin
            entry.has_end = 1'b1;
            if (n_byte_count < MIN_FRAME) begin
                entry.status = ST_TOO_SHORT;
            end else if (n_phase == PH_ERR) begin
                entry.status = ST_BAD_SVC;
            end else if (n_phase != PH_DONE) begin
                entry.status = ST_TRUNC;
            end else begin
                entry.status = ST_OK;
            end
            entry.svc_total = (n_phase == PH_ERR) ? 5'd0 : 5'(n_svc_pos);
            entry.blk_total = n_blk_pos;

            n_phase      = PH_ID;
            n_byte_count = 4'd0;
            n_pos        = 3'd0;
            n_svc_decl   = '0;
            n_svc_pos    = '0;
            n_blk_decl   = 8'd0;
            n_blk_pos    = 8'd0;
            n_hdr        = 8'd0;
            n_low        = 8'd0;
        end
    end

    assign o_push  = i_accept && (entry.has_data || entry.has_end);
    assign o_entry = entry;

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_ID;
            r_byte_count <= 4'd0;
            r_pos        <= 3'd0;
            r_svc_decl   <= '0;
            r_svc_pos    <= '0;
            r_blk_decl   <= 8'd0;
            r_blk_pos    <= 8'd0;
            r_hdr        <= 8'd0;
            r_low        <= 8'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_pos        <= n_pos;
            r_svc_decl   <= n_svc_decl;
            r_svc_pos    <= n_svc_pos;
            r_blk_decl   <= n_blk_decl;
            r_blk_pos    <= n_blk_pos;
            r_hdr        <= n_hdr;
            r_low        <= n_low;
        end
    end

endmodule

`default_nettype wire

// File: sv/rcfp_queue.sv
// Small register queue between parser front end and result back end.
// Holds rcfp_pkg::t_entry items. Uses rcfp_pkg.
`default_nettype none

module rcfp_queue #(
    parameter int DEPTH = rcfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rcfp_pkg::t_entry i_wdata,
    input  logic             i_pop,
    output rcfp_pkg::t_entry o_rdata,
    output logic             o_empty,
    output logic             o_full
);
    import rcfp_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;
    logic            do_push;
    logic            do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// File: sv/rcfp_back.sv
// Back end of the read command frame parser: expands queue entries into
// output transactions held in an output register. Uses rcfp_pkg.
`default_nettype none

module rcfp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rcfp_pkg::t_entry    i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rcfp_pkg::t_out_item o_out_item
);
    import rcfp_pkg::*;

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_data_sent, n_data_sent;
    logic      can_load;
    logic      send_data;
    t_out_item data_item;
    t_out_item end_item;

    assign can_load  = !r_out_valid || i_out_ready;
    assign send_data = i_head.has_data && !r_data_sent;

    // Data result: header fields only matter for block elements
    always_comb begin
        data_item               = '0;
        data_item.out_kind      = i_head.kind;
        data_item.item_index    = i_head.index;
        data_item.item_value    = i_head.value;
        data_item.service_order = i_head.header[3:0];
        data_item.acc_mode      = i_head.header[6:4];
        data_item.short_form    = i_head.header[7];
    end

    // End result
    always_comb begin
        end_item               = '0;
        end_item.out_kind      = KIND_END;
        end_item.status        = i_head.status;
        end_item.service_total = i_head.svc_total;
        end_item.block_total   = i_head.blk_total;
        end_item.frame_done    = 1'b1;
    end

    // Pop once the last transaction of the head entry is loaded
    always_comb begin
        o_pop       = 1'b0;
        n_data_sent = r_data_sent;
        if (can_load && !i_empty) begin
            if (send_data && i_head.has_end) begin
                n_data_sent = 1'b1;
            end else begin
                o_pop       = 1'b1;
                n_data_sent = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_data_sent <= 1'b0;
        end else begin
            r_data_sent <= n_data_sent;
            if (can_load) begin
                r_out_valid <= !i_empty;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (can_load && !i_empty) begin
            r_out <= send_data ? data_item : end_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: sv/read_command_frame_parser_top.sv
// Read command frame parser, top level. One byte accepted per cycle while the queue has room.
// Path: a byte's result is written into a queue entry, then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full; a final byte that also yields
// an ID, service or block result gives two results, loaded into the output register in turn.
// Reset: synchronous, active low; clears parser phase, queue and output valid.
`default_nettype none

module read_command_frame_parser_top #(
    parameter int MAX_SERVICES = rcfp_pkg::MAX_SERVICES_DEF,
    parameter int QUEUE_DEPTH  = rcfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rcfp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rcfp_pkg::t_out_item o_out_item
);
    import rcfp_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    t_entry wr_entry;
    t_entry head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && !full;

    rcfp_front #(
        .MAX_SERVICES(MAX_SERVICES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_entry  (wr_entry)
    );

    rcfp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_entry),
        .i_pop   (pop),
        .o_rdata (head),
        .o_empty (empty),
        .o_full  (full)
    );

    rcfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for read_command_frame_parser_top: sends read-command frames a byte at a time
// and checks every result against a frame parser model kept inside the testbench.
// Depends on rcfp_pkg and the parser RTL only.

module tb;
    import rcfp_pkg::*;

    localparam int ID_BYTES       = 8;
    localparam int IDLE_MAX       = 16;
    localparam int RANDOM_BYTES   = 550;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int DRAIN_CYCLES   = 8;

    // Parser phases of the frame model
    typedef enum logic [2:0] {
        PH_ID, PH_SVC_COUNT, PH_SVC, PH_BLK_COUNT,
        PH_BLK_HEADER, PH_BLK_DATA, PH_DONE, PH_ERR
    } t_parse_phase;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // Frame model state
    t_parse_phase parse_ph;
    logic [3:0]   seen_bytes;
    logic [3:0]   field_pos;
    logic [4:0]   svc_declared;
    logic [4:0]   svc_pos;
    logic [7:0]   blk_declared;
    logic [7:0]   blk_pos;
    logic [7:0]   held_hdr;
    logic [7:0]   low_byte;

    t_out_item  expected_results[$];
    logic [7:0] frame_bytes[$];
    int         bytes_sent = 0;
    int         mismatches = 0;
    int         tx_idle_max;
    int         rx_idle_max;
    int         stall_left = 0;

    read_command_frame_parser_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Frame model
    // ---------------------------------------------------------------
    function automatic void clear_parser();
        parse_ph     = PH_ID;
        seen_bytes   = '0;
        field_pos    = '0;
        svc_declared = '0;
        svc_pos      = '0;
        blk_declared = '0;
        blk_pos      = '0;
        held_hdr     = '0;
        low_byte     = '0;
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [7:0] idx,
                                        input logic [15:0] val, input logic [7:0] hdr);
        t_out_item r;
        r            = '0;
        r.out_kind   = kind;
        r.item_index = idx;
        r.item_value = val;
        if (kind == KIND_BLOCK) begin
            r.service_order = hdr[3:0];
            r.acc_mode      = hdr[6:4];
            r.short_form    = hdr[7];
        end
        expected_results = {expected_results, r};
    endfunction

    // Advance the model by one byte and queue the results it causes
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        t_out_item   fin;
        logic        complete;
        logic [15:0] val;
        complete = 1'b0;
        val      = '0;
        if (seen_bytes < MIN_FRAME)
            seen_bytes++;
        case (parse_ph)
            PH_ID: begin
                push_result(KIND_ID, {4'd0, field_pos}, {8'h00, b}, 8'h00);
                if (field_pos == 4'(ID_BYTES - 1)) begin
                    field_pos = '0;
                    parse_ph  = PH_SVC_COUNT;
                end else begin
                    field_pos++;
                end
            end
            PH_SVC_COUNT: begin
                if (b == 8'd0 || b > 8'(MAX_SERVICES_DEF)) begin
                    parse_ph = PH_ERR;
                end else begin
                    svc_declared = b[4:0];
                    svc_pos      = '0;
                    field_pos    = '0;
                    parse_ph     = PH_SVC;
                end
            end
            PH_SVC: begin
                if (field_pos == 4'd0) begin
                    low_byte  = b;
                    field_pos = 4'd1;
                end else begin
                    // first wire byte is the high byte
                    push_result(KIND_SVC, {3'd0, svc_pos}, {low_byte, b}, 8'h00);
                    svc_pos++;
                    field_pos = '0;
                    if (svc_pos >= svc_declared)
                        parse_ph = PH_BLK_COUNT;
                end
            end
            PH_BLK_COUNT: begin
                blk_declared = b;
                blk_pos      = '0;
                parse_ph     = (b == 8'd0) ? PH_DONE : PH_BLK_HEADER;
            end
            PH_BLK_HEADER: begin
                held_hdr  = b;
                field_pos = '0;
                parse_ph  = PH_BLK_DATA;
            end
            PH_BLK_DATA: begin
                if (held_hdr[7]) begin
                    val      = {8'h00, b};
                    complete = 1'b1;
                end else if (field_pos == 4'd0) begin
                    low_byte  = b;
                    field_pos = 4'd1;
                end else begin
                    // two-byte number, little endian
                    val      = {b, low_byte};
                    complete = 1'b1;
                end
                if (complete) begin
                    push_result(KIND_BLOCK, blk_pos, val, held_hdr);
                    blk_pos++;
                    field_pos = '0;
                    parse_ph  = (blk_pos == blk_declared) ? PH_DONE : PH_BLK_HEADER;
                end
            end
            default: ;
        endcase

        // End result closes the frame
        if (last) begin
            fin            = '0;
            fin.out_kind   = KIND_END;
            fin.frame_done = 1'b1;
            if (seen_bytes < MIN_FRAME)
                fin.status = ST_TOO_SHORT;
            else if (parse_ph == PH_ERR)
                fin.status = ST_BAD_SVC;
            else if (parse_ph != PH_DONE)
                fin.status = ST_TRUNC;
            else
                fin.status = ST_OK;
            fin.service_total = (parse_ph == PH_ERR) ? 5'd0 : svc_pos;
            fin.block_total   = blk_pos;
            expected_results  = {expected_results, fin};
            clear_parser();
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checking and output-side stalls
    // ---------------------------------------------------------------
    function automatic string fmt_result(input t_out_item r);
        return $sformatf({"kind=%0d idx=%0d val=%h ord=%0d mode=%0d sf=%0d",
                          " st=%0d svc=%0d blk=%0d done=%0d"},
                         r.out_kind, r.item_index, r.item_value, r.service_order,
                         r.acc_mode, r.short_form, r.status, r.service_total,
                         r.block_total, r.frame_done);
    endfunction

    task automatic check_result(input t_out_item act);
        t_out_item want;
        string     diff;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: %s", fmt_result(act));
        end else begin
            want = expected_results.pop_front();
            diff = "";
            if (act.out_kind      !== want.out_kind)      diff = {diff, " out_kind"};
            if (act.item_index    !== want.item_index)    diff = {diff, " item_index"};
            if (act.item_value    !== want.item_value)    diff = {diff, " item_value"};
            if (act.service_order !== want.service_order) diff = {diff, " service_order"};
            if (act.acc_mode      !== want.acc_mode)      diff = {diff, " acc_mode"};
            if (act.short_form    !== want.short_form)    diff = {diff, " short_form"};
            if (act.status        !== want.status)        diff = {diff, " status"};
            if (act.service_total !== want.service_total) diff = {diff, " service_total"};
            if (act.block_total   !== want.block_total)   diff = {diff, " block_total"};
            if (act.frame_done    !== want.frame_done)    diff = {diff, " frame_done"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in%s\n  expected %s\n  actual   %s",
                             diff, fmt_result(want), fmt_result(act));
            end
        end
    endtask

    // Check each output transaction, then draw the stall before the next one
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                check_result(out_item);
                stall_left = $urandom_range(rx_idle_max, 0);
                if (stall_left != 0)
                    out_ready <= 1'b0;
            end else if (!out_ready) begin
                if (stall_left <= 1) begin
                    stall_left = 0;
                    out_ready <= 1'b1;
                end else begin
                    stall_left--;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    // One input transaction; valid stays up if the next byte follows at once
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = $urandom_range(tx_idle_max, 0);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{in_byte: value, in_last: last};
        do
            @(posedge clk);
        while (!in_ready);
        predict_byte(value, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame_bytes.size(); k++)
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Well-formed frame with random content
    task automatic fill_frame(input int svc_n, input int blk_n);
        int         k;
        logic [7:0] hdr;
        frame_bytes.delete();
        for (k = 0; k < ID_BYTES; k++)
            frame_bytes = {frame_bytes, 8'($urandom)};
        frame_bytes = {frame_bytes, 8'(svc_n)};
        for (k = 0; k < 2 * svc_n; k++)
            frame_bytes = {frame_bytes, 8'($urandom)};
        frame_bytes = {frame_bytes, 8'(blk_n)};
        for (k = 0; k < blk_n; k++) begin
            hdr = 8'($urandom);
            frame_bytes = {frame_bytes, hdr};
            frame_bytes = {frame_bytes, 8'($urandom)};
            if (!hdr[7])
                frame_bytes = {frame_bytes, 8'($urandom)};
        end
    endtask

    task automatic send_random_frame();
        int pick;
        int svc_n;
        int blk_n;
        int cut;
        int k;
        pick  = $urandom_range(99, 0);
        svc_n = ($urandom_range(7, 0) == 0) ? MAX_SERVICES_DEF : $urandom_range(4, 1);
        blk_n = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 5) : $urandom_range(4, 0);
        fill_frame(svc_n, blk_n);
        if (pick < 60) begin
            // complete frame, sometimes with trailing bytes to be ignored
            if ($urandom_range(3, 0) == 0)
                for (k = $urandom_range(4, 1); k > 0; k--)
                    frame_bytes = {frame_bytes, 8'($urandom)};
        end else if (pick < 78) begin
            // cut anywhere: too short, before the block count, or mid element
            cut = $urandom_range(frame_bytes.size() - 1, 1);
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end else if (pick < 90) begin
            // service count out of range
            frame_bytes[ID_BYTES] = $urandom_range(1, 0) ? 8'd0 :
                                    8'($urandom_range(255, MAX_SERVICES_DEF + 1));
        end else begin
            // noise
            frame_bytes.delete();
            for (k = $urandom_range(20, 1); k > 0; k--)
                frame_bytes = {frame_bytes, 8'($urandom)};
        end
        send_frame();
    endtask

    // Good frame with both element forms, a one-byte frame, a bad service count
    task automatic test_directed();
        frame_bytes = {8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'h55, 8'haa,
                       8'h01, 8'hff, 8'h00, 8'h02,
                       8'hff, 8'h00,
                       8'h10, 8'h34, 8'h12};
        send_frame();
        frame_bytes = {8'h5a};
        send_frame();
        frame_bytes = {8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
                       8'h00, 8'h01, 8'h02, 8'h03};
        send_frame();
    endtask

    // No idling on either side
    task automatic test_back_to_back();
        int k;
        tx_idle_max = 0;
        rx_idle_max = 0;
        for (k = 0; k < 10; k++)
            send_random_frame();
        tx_idle_max = IDLE_MAX;
        rx_idle_max = IDLE_MAX;
    endtask

    // Largest service and block counts
    task automatic test_max_blocks();
        fill_frame(MAX_SERVICES_DEF, 255);
        send_frame();
    endtask

    task automatic test_random_frames();
        int frames;
        int start;
        frames = 0;
        start  = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            // stretches with and without idling, chosen at random
            if (frames % 8 == 0) begin
                tx_idle_max = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
                rx_idle_max = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
            end
            send_random_frame();
            frames++;
            if (frames % 10 == 0)
                pause_until_drained();
        end
    endtask

    initial begin : stimulus
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        tx_idle_max = IDLE_MAX;
        rx_idle_max = IDLE_MAX;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_back_to_back();
        test_max_blocks();
        test_random_frames();

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
sv/rcfp_pkg.sv
sv/rcfp_front.sv
sv/rcfp_queue.sv
sv/rcfp_back.sv
sv/read_command_frame_parser_top.sv
test/tb.sv
